### design/max_flow_min_cut_macros.svh
// ----------------------------------------------------------------------------
// Max-flow engine assertion macros
// Shared concurrent assertion shorthands for the max-flow design.
// ----------------------------------------------------------------------------
`ifndef MAX_FLOW_MIN_CUT_MACROS_SVH
`define MAX_FLOW_MIN_CUT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define MFMC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define MFMC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/mfmc_pkg.sv
// ----------------------------------------------------------------------------
// Max-flow engine package
// Fixed widths, operation codes and shared types of the max-flow engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mfmc_pkg;

    // Fixed port widths.
    localparam int OP_W    = 2;
    localparam int VTX_W   = 6;
    localparam int CAP_W   = 16;
    localparam int FLOW_W  = 24;
    localparam int MASK_W  = 64;

    localparam logic [FLOW_W-1:0] FLOW_MAX = {FLOW_W{1'b1}};

    // Operation codes.
    localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
    localparam logic [OP_W-1:0] OP_RUN   = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    // Request bundle to the search queue and parent-link memories.
    typedef struct packed {
        logic             q_we;
        logic [VTX_W-1:0] q_waddr;
        logic [VTX_W-1:0] q_wdata;
        logic [VTX_W-1:0] q_raddr;
        logic             p_we;
        logic [VTX_W-1:0] p_waddr;
        logic [VTX_W-1:0] p_wdata;
        logic [VTX_W-1:0] p_raddr;
    } t_srch_req;

endpackage

### design/mfmc_matrix.sv
// ----------------------------------------------------------------------------
// Residual matrix memory
// One write port and one registered read port over all vertex pairs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mfmc_matrix import mfmc_pkg::*; #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 24,
    parameter int AW    = 12
) (
    input  logic                    i_clk,
    input  logic                    i_we,
    input  logic [AW-1:0]           i_waddr,
    input  logic signed [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]           i_raddr,
    output logic signed [WIDTH-1:0] o_rdata
);

    logic signed [WIDTH-1:0] r_mem [DEPTH];
    logic signed [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### design/mfmc_search_mem.sv
// ----------------------------------------------------------------------------
// Search memories
// Breadth-first queue and parent links, each one write and one read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mfmc_search_mem import mfmc_pkg::*; #(
    parameter int VERTEX_COUNT = 64,
    parameter int VW           = 6
) (
    input  logic          i_clk,
    input  t_srch_req     i_req,
    output logic [VW-1:0] o_q_rdata,
    output logic [VW-1:0] o_p_rdata
);

    logic [VW-1:0] r_queue  [VERTEX_COUNT];
    logic [VW-1:0] r_parent [VERTEX_COUNT];
    logic [VW-1:0] r_q_rdata;
    logic [VW-1:0] r_p_rdata;

    // Queue memory.
    always_ff @(posedge i_clk) begin
        if (i_req.q_we) begin
            r_queue[i_req.q_waddr[VW-1:0]] <= i_req.q_wdata[VW-1:0];
        end
        r_q_rdata <= r_queue[i_req.q_raddr[VW-1:0]];
    end

    // Parent-link memory.
    always_ff @(posedge i_clk) begin
        if (i_req.p_we) begin
            r_parent[i_req.p_waddr[VW-1:0]] <= i_req.p_wdata[VW-1:0];
        end
        r_p_rdata <= r_parent[i_req.p_raddr[VW-1:0]];
    end

    assign o_q_rdata = r_q_rdata;
    assign o_p_rdata = r_p_rdata;

endmodule

### design/max_flow_min_cut.sv
// ----------------------------------------------------------------------------
// Max-flow min-cut engine
// Dense residual-matrix Edmonds-Karp engine with a minimum-cut report.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake               Payload
//  command   in         start high, busy low    i_opcode, i_from_vertex,
//                                               i_to_vertex, i_capacity
//  result    out        o_result_valid strobe   o_max_flow, o_source_side_mask
//
//  An add reads the matrix entry, then writes it back; clear and reset each
//  run a clearing pass over all VERTEX_COUNT^2 entries, one entry per cycle.
//  A run repeats, per augmenting path, a search that scans the matrix row of
//  each queued vertex through the single matrix read port, a bottleneck walk
//  and a residual update over the edges of the path, with each edge in turn.
//  busy is high from acceptance until the transaction ends; the result
//  strobe comes in the cycle after the run finishes and cannot be stalled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "max_flow_min_cut_macros.svh"

module max_flow_min_cut import mfmc_pkg::*; #(
    parameter int VERTEX_COUNT   = 64,
    parameter int CAPACITY_WIDTH = 24
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [OP_W-1:0]          i_opcode,
    input  logic [VTX_W-1:0]         i_from_vertex,
    input  logic [VTX_W-1:0]         i_to_vertex,
    input  logic signed [CAP_W-1:0]  i_capacity,
    output logic                     o_result_valid,
    output logic [FLOW_W-1:0]        o_max_flow,
    output logic [MASK_W-1:0]        o_source_side_mask
);

    localparam int VW    = (VERTEX_COUNT > 1) ? $clog2(VERTEX_COUNT) : 1;
    localparam int DEPTH = VERTEX_COUNT * VERTEX_COUNT;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = CAPACITY_WIDTH;
    localparam int AddW  = ((CW > CAP_W) ? CW : CAP_W) + 1;
    localparam int SumW  = ((CW > FLOW_W) ? CW : FLOW_W) + 1;

    localparam logic signed [CW-1:0] ENTRY_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] ENTRY_MIN = {1'b1, {(CW-1){1'b0}}};

    // Controller state codes.
    localparam logic [3:0] S_CLR      = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_ADD_WR   = 4'd2;
    localparam logic [3:0] S_BFS_INIT = 4'd3;
    localparam logic [3:0] S_Q_RD     = 4'd4;
    localparam logic [3:0] S_Q_WAIT   = 4'd5;
    localparam logic [3:0] S_SCAN     = 4'd6;
    localparam logic [3:0] S_SCAN_END = 4'd7;
    localparam logic [3:0] S_SRCH_END = 4'd8;
    localparam logic [3:0] S_B_PAR    = 4'd9;
    localparam logic [3:0] S_B_MAT    = 4'd10;
    localparam logic [3:0] S_B_CMP    = 4'd11;
    localparam logic [3:0] S_U_PAR    = 4'd12;
    localparam logic [3:0] S_U_RDF    = 4'd13;
    localparam logic [3:0] S_U_WRF    = 4'd14;
    localparam logic [3:0] S_U_WRR    = 4'd15;

    function automatic logic [AW-1:0] mat_addr(input logic [VW-1:0] u, input logic [VW-1:0] v);
        return AW'(int'(u) * VERTEX_COUNT + int'(v));
    endfunction

    logic [3:0]               r_state, n_state;
    logic [AW-1:0]            r_clr_addr, n_clr_addr;
    logic [AW-1:0]            r_addr, n_addr;
    logic signed [CAP_W-1:0]  r_cap, n_cap;
    logic [VW-1:0]            r_src, n_src;
    logic [VW-1:0]            r_snk, n_snk;
    logic                     r_final, n_final;
    logic [VERTEX_COUNT-1:0]  r_visited, n_visited;
    logic [VW:0]              r_head, n_head;
    logic [VW:0]              r_tail, n_tail;
    logic [VW-1:0]            r_u, n_u;
    logic [VW-1:0]            r_scan, n_scan;
    logic                     r_pend, n_pend;
    logic [VW-1:0]            r_pend_v, n_pend_v;
    logic [VW-1:0]            r_cur, n_cur;
    logic [VW-1:0]            r_par, n_par;
    logic signed [CW-1:0]     r_bneck, n_bneck;
    logic [FLOW_W-1:0]        r_flow, n_flow;
    logic                     r_out_valid, n_out_valid;
    logic [FLOW_W-1:0]        r_out_flow, n_out_flow;
    logic [MASK_W-1:0]        r_out_mask, n_out_mask;

    logic                     mat_we;
    logic [AW-1:0]            mat_waddr;
    logic signed [CW-1:0]     mat_wdata;
    logic [AW-1:0]            mat_raddr;
    logic signed [CW-1:0]     mat_rdata;
    t_srch_req                srch_req;
    logic [VW-1:0]            q_rdata;
    logic [VW-1:0]            p_rdata;

    logic                     from_ok, to_ok;
    logic signed [AddW-1:0]   add_sum;
    logic signed [CW-1:0]     add_clamped;
    logic signed [CW:0]       rev_sum;
    logic signed [CW-1:0]     rev_clamped;
    logic [SumW-1:0]          flow_sum;

    assign from_ok = {1'b0, i_from_vertex} < (VTX_W+1)'(VERTEX_COUNT);
    assign to_ok   = {1'b0, i_to_vertex} < (VTX_W+1)'(VERTEX_COUNT);

    // Saturating arithmetic for adds, reverse residuals and the flow total.
    always_comb begin
        add_sum = AddW'(mat_rdata) + AddW'(r_cap);
        if (add_sum > AddW'(ENTRY_MAX)) begin
            add_clamped = ENTRY_MAX;
        end else if (add_sum < AddW'(ENTRY_MIN)) begin
            add_clamped = ENTRY_MIN;
        end else begin
            add_clamped = CW'(add_sum);
        end
        rev_sum = (CW+1)'(mat_rdata) + (CW+1)'(r_bneck);
        if (rev_sum > (CW+1)'(ENTRY_MAX)) begin
            rev_clamped = ENTRY_MAX;
        end else begin
            rev_clamped = CW'(rev_sum);
        end
        flow_sum = SumW'(r_flow) + SumW'($unsigned(r_bneck));
    end

    // Controller next-state logic.
    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_addr      = r_addr;
        n_cap       = r_cap;
        n_src       = r_src;
        n_snk       = r_snk;
        n_final     = r_final;
        n_visited   = r_visited;
        n_head      = r_head;
        n_tail      = r_tail;
        n_u         = r_u;
        n_scan      = r_scan;
        n_pend      = 1'b0;
        n_pend_v    = r_pend_v;
        n_cur       = r_cur;
        n_par       = r_par;
        n_bneck     = r_bneck;
        n_flow      = r_flow;
        n_out_valid = 1'b0;
        n_out_flow  = r_out_flow;
        n_out_mask  = r_out_mask;
        mat_we      = 1'b0;
        mat_waddr   = r_addr;
        mat_wdata   = '0;
        mat_raddr   = r_addr;
        srch_req    = '0;

        // Result of the previous scan read: discover a new vertex.
        if (r_pend && (mat_rdata > 0) && !r_visited[r_pend_v]) begin
            n_visited[r_pend_v] = 1'b1;
            srch_req.q_we    = 1'b1;
            srch_req.q_waddr = VTX_W'(r_tail[VW-1:0]);
            srch_req.q_wdata = VTX_W'(r_pend_v);
            srch_req.p_we    = 1'b1;
            srch_req.p_waddr = VTX_W'(r_pend_v);
            srch_req.p_wdata = VTX_W'(r_u);
            n_tail = r_tail + 1'b1;
        end

        unique case (r_state)
            S_CLR: begin
                mat_we    = 1'b1;
                mat_waddr = r_clr_addr;
                if (r_clr_addr == AW'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr_addr = r_clr_addr + 1'b1;
                end
            end
            S_IDLE: begin
                if (start) begin
                    unique case (i_opcode)
                        OP_ADD: begin
                            if (from_ok && to_ok) begin
                                n_addr    = mat_addr(i_from_vertex[VW-1:0],
                                                     i_to_vertex[VW-1:0]);
                                mat_raddr = n_addr;
                                n_cap     = i_capacity;
                                n_state   = S_ADD_WR;
                            end
                        end
                        OP_RUN: begin
                            n_flow = '0;
                            if (from_ok && to_ok) begin
                                n_src   = i_from_vertex[VW-1:0];
                                n_snk   = i_to_vertex[VW-1:0];
                                n_final = (i_from_vertex == i_to_vertex);
                                n_state = S_BFS_INIT;
                            end else begin
                                n_out_valid = 1'b1;
                                n_out_flow  = '0;
                                n_out_mask  = '0;
                            end
                        end
                        OP_CLEAR: begin
                            n_clr_addr = '0;
                            n_state    = S_CLR;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_ADD_WR: begin
                mat_we    = 1'b1;
                mat_wdata = add_clamped;
                n_state   = S_IDLE;
            end
            S_BFS_INIT: begin
                n_visited        = '0;
                n_visited[r_src] = 1'b1;
                srch_req.q_we    = 1'b1;
                srch_req.q_waddr = '0;
                srch_req.q_wdata = VTX_W'(r_src);
                n_head  = '0;
                n_tail  = (VW+1)'(1);
                n_state = S_Q_RD;
            end
            S_Q_RD: begin
                if (r_head == r_tail) begin
                    n_state = S_SRCH_END;
                end else begin
                    srch_req.q_raddr = VTX_W'(r_head[VW-1:0]);
                    n_state = S_Q_WAIT;
                end
            end
            S_Q_WAIT: begin
                n_u     = q_rdata;
                n_scan  = '0;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                mat_raddr = mat_addr(r_u, r_scan);
                n_pend    = 1'b1;
                n_pend_v  = r_scan;
                if (r_scan == VW'(VERTEX_COUNT - 1)) begin
                    n_state = S_SCAN_END;
                end else begin
                    n_scan = r_scan + 1'b1;
                end
            end
            S_SCAN_END: begin
                n_head  = r_head + 1'b1;
                n_state = S_Q_RD;
            end
            S_SRCH_END: begin
                if (r_final) begin
                    n_out_valid = 1'b1;
                    n_out_flow  = r_flow;
                    n_out_mask  = MASK_W'(r_visited);
                    n_state     = S_IDLE;
                end else if (!r_visited[r_snk]) begin
                    n_final = 1'b1;
                    n_state = S_BFS_INIT;
                end else begin
                    n_cur   = r_snk;
                    n_bneck = ENTRY_MAX;
                    n_state = S_B_PAR;
                end
            end
            S_B_PAR: begin
                srch_req.p_raddr = VTX_W'(r_cur);
                n_state = S_B_MAT;
            end
            S_B_MAT: begin
                n_par     = p_rdata;
                mat_raddr = mat_addr(p_rdata, r_cur);
                n_state   = S_B_CMP;
            end
            S_B_CMP: begin
                if (mat_rdata < r_bneck) begin
                    n_bneck = mat_rdata;
                end
                if (r_par == r_src) begin
                    n_cur   = r_snk;
                    n_state = S_U_PAR;
                end else begin
                    n_cur   = r_par;
                    n_state = S_B_PAR;
                end
            end
            S_U_PAR: begin
                srch_req.p_raddr = VTX_W'(r_cur);
                n_state = S_U_RDF;
            end
            S_U_RDF: begin
                n_par     = p_rdata;
                mat_raddr = mat_addr(p_rdata, r_cur);
                n_state   = S_U_WRF;
            end
            S_U_WRF: begin
                mat_we    = 1'b1;
                mat_waddr = mat_addr(r_par, r_cur);
                mat_wdata = mat_rdata - r_bneck;
                mat_raddr = mat_addr(r_cur, r_par);
                n_state   = S_U_WRR;
            end
            S_U_WRR: begin
                mat_we    = 1'b1;
                mat_waddr = mat_addr(r_cur, r_par);
                mat_wdata = rev_clamped;
                n_cur     = r_par;
                if (r_par == r_src) begin
                    if (flow_sum > SumW'(FLOW_MAX)) begin
                        n_flow = FLOW_MAX;
                    end else begin
                        n_flow = FLOW_W'(flow_sum);
                    end
                    n_state = S_BFS_INIT;
                end else begin
                    n_state = S_U_PAR;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr_addr  <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
            r_flow      <= '0;
            r_visited   <= '0;
            r_final     <= 1'b0;
            r_head      <= '0;
            r_tail      <= '0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
            r_flow      <= n_flow;
            r_visited   <= n_visited;
            r_final     <= n_final;
            r_head      <= n_head;
            r_tail      <= n_tail;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_addr     <= n_addr;
        r_cap      <= n_cap;
        r_src      <= n_src;
        r_snk      <= n_snk;
        r_u        <= n_u;
        r_scan     <= n_scan;
        r_pend_v   <= n_pend_v;
        r_cur      <= n_cur;
        r_par      <= n_par;
        r_bneck    <= n_bneck;
        r_out_flow <= n_out_flow;
        r_out_mask <= n_out_mask;
    end

    mfmc_matrix #(
        .DEPTH (DEPTH),
        .WIDTH (CW),
        .AW    (AW)
    ) u_matrix (
        .i_clk   (i_clk),
        .i_we    (mat_we),
        .i_waddr (mat_waddr),
        .i_wdata (mat_wdata),
        .i_raddr (mat_raddr),
        .o_rdata (mat_rdata)
    );

    mfmc_search_mem #(
        .VERTEX_COUNT (VERTEX_COUNT),
        .VW           (VW)
    ) u_search_mem (
        .i_clk     (i_clk),
        .i_req     (srch_req),
        .o_q_rdata (q_rdata),
        .o_p_rdata (p_rdata)
    );

    assign busy               = (r_state != S_IDLE);
    assign o_result_valid     = r_out_valid;
    assign o_max_flow         = r_out_flow;
    assign o_source_side_mask = r_out_mask;

    // The result strobe only follows the end of a transaction.
    `MFMC_ASSERT_NOW(a_result_idle, o_result_valid, r_state == S_IDLE, "result while busy")
    // The queue never holds more vertices than the graph has.
    `MFMC_ASSERT_NOW(a_tail_bound, 1'b1, r_tail <= (VW+1)'(VERTEX_COUNT), "queue overrun")
    // An augmenting path always carries a positive bottleneck.
    `MFMC_ASSERT_NOW(a_bneck_pos, r_state == S_U_PAR, r_bneck > 0, "bottleneck not positive")
    // The source stays visited while its search scans.
    `MFMC_ASSERT_NOW(a_src_visited, r_state == S_SCAN, r_visited[r_src], "source not visited")
    // A scan of the last vertex is always followed by the scan wrap-up.
    `MFMC_ASSERT_NXT(a_scan_end, (r_state == S_SCAN) && (r_scan == VW'(VERTEX_COUNT - 1)),
        r_state == S_SCAN_END, "scan did not close")

endmodule
